// ===== src/kcc_pkg.sv =====
package kcc_pkg;

    localparam int NUM_KEYS = 4;
    localparam int PIN_W    = 4;
    localparam int KEY_W    = 2;
    localparam int CNT_W    = 16;
    localparam int FLAG_W   = 3;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] LONG_PRESS_RESET  = CNT_W'(100);
    localparam logic [CNT_W-1:0] DOUBLE_WIN_RESET  = CNT_W'(30);

    localparam logic [1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [1:0] REG_DOUBLE_WIN = 2'd1;
    localparam logic [1:0] REG_SCAN_MODE  = 2'd2;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic MODE_FULL   = 1'b0;
    localparam logic MODE_SIMPLE = 1'b1;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_PUSH   = 2'd1;
    localparam logic [1:0] EV_LONG   = 2'd2;
    localparam logic [1:0] EV_DOUBLE = 2'd3;

    localparam logic [FLAG_W-1:0] FL_PUSH   = 3'b001;
    localparam logic [FLAG_W-1:0] FL_LONG   = 3'b010;
    localparam logic [FLAG_W-1:0] FL_DOUBLE = 3'b100;
    localparam logic [FLAG_W-1:0] FL_NONE   = 3'b000;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_PRESS   = 5'b00010,
        PH_HOLD    = 5'b00100,
        PH_WINDOW  = 5'b01000,
        PH_RELEASE = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] double_click_window;
        logic             scan_mode;
    } cfg_t;

    typedef struct packed {
        logic             req_type;
        logic [PIN_W-1:0] pin_levels;
        logic [KEY_W-1:0] key_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       event_code;
        logic [KEY_W-1:0] event_key;
    } out_word_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== src/kcc_key.sv =====
module kcc_key (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kcc_pkg::cfg_t                 cfg,
    input  logic                          step,
    input  logic                          pressed,
    input  logic [kcc_pkg::FLAG_W-1:0]    clr_mask,
    output logic [kcc_pkg::FLAG_W-1:0]    flags
);
    import kcc_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   hold_reg, hold_next;
    logic [CNT_W-1:0]   win_reg, win_next;
    logic [FLAG_W-1:0]  flags_reg, flags_next;
    logic [FLAG_W-1:0]  set_mask;
    logic [CNT_W-1:0]   hold_inc;
    logic [CNT_W-1:0]   win_inc;

    assign hold_inc = sat_inc(hold_reg);
    assign win_inc  = sat_inc(win_reg);

    always_comb begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        win_next   = win_reg;
        set_mask   = FL_NONE;
        if (step) begin
            if (cfg.scan_mode == MODE_SIMPLE) begin
                unique case (phase_reg)
                    PH_PRESS: begin
                        phase_next = pressed ? PH_HOLD : PH_IDLE;
                    end
                    PH_HOLD: begin
                        if (!pressed) begin
                            set_mask   = FL_PUSH;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WINDOW, PH_RELEASE: begin
                        if (!pressed) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = pressed ? PH_PRESS : PH_IDLE;
                    end
                endcase
            end else begin
                unique case (phase_reg)
                    PH_PRESS: begin
                        if (pressed) begin
                            phase_next = PH_HOLD;
                            hold_next  = '0;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_HOLD: begin
                        if (pressed) begin
                            if (hold_inc >= cfg.long_press_ticks) begin
                                hold_next  = '0;
                                phase_next = PH_RELEASE;
                                set_mask   = FL_LONG;
                            end else begin
                                hold_next = hold_inc;
                            end
                        end else begin
                            hold_next  = '0;
                            win_next   = '0;
                            phase_next = PH_WINDOW;
                        end
                    end
                    PH_WINDOW: begin
                        if (pressed && win_inc <= cfg.double_click_window) begin
                            phase_next = PH_RELEASE;
                            win_next   = '0;
                            set_mask   = FL_DOUBLE;
                        end else if (!pressed && win_inc > cfg.double_click_window) begin
                            phase_next = PH_IDLE;
                            win_next   = '0;
                            set_mask   = FL_PUSH;
                        end else begin
                            win_next = win_inc;
                        end
                    end
                    PH_RELEASE: begin
                        if (!pressed) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = pressed ? PH_PRESS : PH_IDLE;
                    end
                endcase
            end
        end
        flags_next = (flags_reg & ~clr_mask) | set_mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            hold_reg  <= '0;
            win_reg   <= '0;
            flags_reg <= FL_NONE;
        end else begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            win_reg   <= win_next;
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

// ===== src/key_click_classifier.sv =====
// Channel  | Ports                          | Word
// ---------+--------------------------------+-----------------------------------
// input    | s_valid, s_ready, s_data       | req_type, pin_levels, key_index
// result   | m_valid, m_ready, m_data       | event_code, event_key
// config   | psel, penable, pwrite, paddr,  | long_press_ticks, double_click_window,
//          | pwdata, prdata, pready         | scan_mode at byte 0x0, 0x4, 0x8
//
// One word per cycle unless a read is held in the input register: a word
// waits in the input register, and the key machines and the flag read work
// between that register and the result register, which drives m_data.
// Synchronous reset clears keys, flags, valid bits and sets config to defaults.
// A full result register with m_ready low holds a read in the input register,
// and the input with it; scan words still pass while no read waits.
module key_click_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  kcc_pkg::in_word_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output kcc_pkg::out_word_t            m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kcc_pkg::PADDR_W-1:0]   paddr,
    input  logic [kcc_pkg::PDATA_W-1:0]   pwdata,
    output logic [kcc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import kcc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    in_word_t   in_data_reg;
    logic       in_valid_reg, in_valid_next;
    out_word_t  out_data_reg, out_data_next;
    logic       out_valid_reg, out_valid_next;

    logic       advance;
    logic       is_read;
    logic       key_ok;
    logic [FLAG_W-1:0] sel_flags;
    logic [FLAG_W-1:0] clr_sel;
    logic [1:0]        code;
    logic [FLAG_W-1:0] key_flags [NUM_KEYS];
    logic [FLAG_W-1:0] key_clr   [NUM_KEYS];
    logic [NUM_KEYS-1:0] key_hit;

    // config port
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_LONG_PRESS: cfg_next.long_press_ticks    = pwdata[CNT_W-1:0];
                REG_DOUBLE_WIN: cfg_next.double_click_window = pwdata[CNT_W-1:0];
                REG_SCAN_MODE:  cfg_next.scan_mode           = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LONG_PRESS: prdata = PDATA_W'(cfg_reg.long_press_ticks);
            REG_DOUBLE_WIN: prdata = PDATA_W'(cfg_reg.double_click_window);
            REG_SCAN_MODE:  prdata = PDATA_W'(cfg_reg.scan_mode);
            default:        prdata = '0;
        endcase
    end

    // handshake
    assign is_read = (in_data_reg.req_type == REQ_READ);
    assign advance = in_valid_reg && (!is_read || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    // flag read for the addressed key
    assign key_ok = (32'(in_data_reg.key_index) < NUM_KEYS);

    always_comb begin
        sel_flags = FL_NONE;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_hit[k] = (32'(in_data_reg.key_index) == k);
            if (key_hit[k]) begin
                sel_flags = key_flags[k];
            end
        end
    end

    always_comb begin
        code    = EV_NONE;
        clr_sel = FL_NONE;
        if (key_ok) begin
            if ((sel_flags & FL_PUSH) != FL_NONE) begin
                code    = EV_PUSH;
                clr_sel = FL_PUSH;
            end else if ((sel_flags & FL_LONG) != FL_NONE) begin
                code    = EV_LONG;
                clr_sel = FL_LONG;
            end else if ((sel_flags & FL_DOUBLE) != FL_NONE) begin
                code    = EV_DOUBLE;
                clr_sel = FL_DOUBLE;
            end
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < NUM_KEYS; gk++) begin : g_key
            logic pressed;
            if (gk < PIN_W) begin : g_pin
                assign pressed = !in_data_reg.pin_levels[gk];
            end else begin : g_nopin
                assign pressed = 1'b0;
            end

            assign key_clr[gk] = (advance && is_read && key_hit[gk]) ? clr_sel : FL_NONE;

            kcc_key u_key (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cfg      (cfg_reg),
                .step     (advance && !is_read),
                .pressed  (pressed),
                .clr_mask (key_clr[gk]),
                .flags    (key_flags[gk])
            );
        end
    endgenerate

    // result register
    always_comb begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance && is_read) begin
            out_valid_next           = 1'b1;
            out_data_next.event_code = code;
            out_data_next.event_key  = in_data_reg.key_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks    <= LONG_PRESS_RESET;
            cfg_reg.double_click_window <= DOUBLE_WIN_RESET;
            cfg_reg.scan_mode           <= MODE_FULL;
            in_valid_reg                <= 1'b0;
            out_valid_reg               <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
